[src/wav_header_parser_defines.svh]
// Assertion macros used by the verification files of the WAV header parser.
`ifndef WAV_HEADER_PARSER_DEFINES_SVH
`define WAV_HEADER_PARSER_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define WAVHP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define WAVHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/wavhp_pkg.sv]
// Types and constants shared by the WAV header parser modules.
package wavhp_pkg;

  localparam int unsigned WORD_W = 32;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_RIFF   = 3'd1;
  localparam logic [2:0] ST_BAD_WAVE   = 3'd2;
  localparam logic [2:0] ST_NOT_PCM    = 3'd3;
  localparam logic [2:0] ST_UNSUPPORT  = 3'd4;
  localparam logic [2:0] ST_SHORT_FMT  = 3'd5;
  localparam logic [2:0] ST_NO_FMT     = 3'd6;
  localparam logic [2:0] ST_NO_DATA    = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] REG_RATE_LOW  = 2'd0;
  localparam logic [1:0] REG_RATE_MID  = 2'd1;
  localparam logic [1:0] REG_RATE_HIGH = 2'd2;

  localparam logic [31:0] RATE_LOW_RST  = 32'd11025;
  localparam logic [31:0] RATE_MID_RST  = 32'd22050;
  localparam logic [31:0] RATE_HIGH_RST = 32'd44100;

  // Chunk tags as gathered little-endian
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] PCM_FORMAT = 16'd1;

  typedef struct packed {
    logic [31:0] low;
    logic [31:0] mid;
    logic [31:0] high;
  } wavhp_rates_t;

  // Header result, without the block count
  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  channel_count;
    logic [31:0] sample_rate;
    logic [5:0]  sample_bits;
    logic [31:0] bytes_per_second;
    logic [15:0] block_bytes;
    logic [31:0] data_length;
    logic [31:0] data_start;
  } wavhp_hdr_t;

  // Request to the divider
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [15:0] den;
  } wavhp_div_req_t;

endpackage

[src/wavhp_divider.sv]
// Restoring divider, one quotient bit per clock.
module wavhp_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wavhp_pkg::wavhp_div_req_t  req,
  output logic                       busy,
  output logic                       done,
  output logic [31:0]                quotient
);

  localparam int unsigned STEP_W = $clog2(wavhp_pkg::WORD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(wavhp_pkg::WORD_W - 1);

  logic [31:0]       rem_r, rem_nxt;
  logic [31:0]       num_r, num_nxt;
  logic [31:0]       quo_r, quo_nxt;
  logic [15:0]       den_r, den_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem_r, num_r[31]};
  assign diff  = trial - {17'd0, den_r};
  assign fits  = trial >= {17'd0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      num_nxt  = req.num;
      quo_nxt  = '0;
      den_nxt  = req.den;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[31:0] : trial[31:0];
      num_nxt  = {num_r[30:0], 1'b0};
      quo_nxt  = {quo_r[30:0], fits};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  // Align of zero gives a zero count
  assign quotient = (den_r == 16'd0) ? 32'd0 : quo_r;

endmodule

[src/wavhp_parser.sv]
// Byte-wise RIFF/WAVE chunk walker: tags, sizes, fmt fields and skipping.
module wavhp_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      take,
  input  logic [7:0]                file_byte,
  input  logic                      first_of_file,
  input  logic                      last_of_file,
  input  wavhp_pkg::wavhp_rates_t   rates,
  output logic                      emit,
  output wavhp_pkg::wavhp_hdr_t     hdr,
  output wavhp_pkg::wavhp_div_req_t div_req
);

  // Parse phases
  localparam logic [3:0] PH_IDLE         = 4'd0;
  localparam logic [3:0] PH_RIFF_TAG     = 4'd1;
  localparam logic [3:0] PH_RIFF_SIZE    = 4'd2;
  localparam logic [3:0] PH_WAVE_TAG     = 4'd3;
  localparam logic [3:0] PH_CHUNK_ID     = 4'd4;
  localparam logic [3:0] PH_CHUNK_SIZE   = 4'd5;
  localparam logic [3:0] PH_FMT_FORMAT   = 4'd6;
  localparam logic [3:0] PH_FMT_CHANNELS = 4'd7;
  localparam logic [3:0] PH_FMT_RATE     = 4'd8;
  localparam logic [3:0] PH_FMT_BYTERATE = 4'd9;
  localparam logic [3:0] PH_FMT_ALIGN    = 4'd10;
  localparam logic [3:0] PH_FMT_BITS     = 4'd11;
  localparam logic [3:0] PH_SKIP         = 4'd12;
  localparam logic [3:0] PH_PAD          = 4'd13;
  localparam logic [3:0] PH_DONE         = 4'd14;

  logic [3:0]  phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic [15:0] chans_r, chans_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] brate_r, brate_nxt;
  logic [15:0] align_r, align_nxt;
  logic [15:0] bits_r, bits_nxt;

  logic        active;
  logic [3:0]  phase_cur;
  logic [1:0]  cnt_cur;
  logic        end4, end2;
  logic [31:0] sh32_tag, sh32_size, sh32_rate, sh32_brate;
  logic [15:0] sh16_chans, sh16_align, sh16_bits;
  logic [31:0] skip_dec, fmt_rest;
  logic        ch_ok, bits_ok, rate_ok;
  logic        err;
  logic        ok;
  logic [2:0]  status;

  // Little-endian gathering: each byte enters at the top and moves down
  assign sh32_tag   = {file_byte, tag_r[31:8]};
  assign sh32_size  = {file_byte, size_r[31:8]};
  assign sh32_rate  = {file_byte, rate_r[31:8]};
  assign sh32_brate = {file_byte, brate_r[31:8]};
  assign sh16_chans = {file_byte, chans_r[15:8]};
  assign sh16_align = {file_byte, align_r[15:8]};
  assign sh16_bits  = {file_byte, bits_r[15:8]};
  assign skip_dec   = skip_r - 32'd1;
  assign fmt_rest   = size_r - 32'd16;

  assign phase_cur = first_of_file ? PH_RIFF_TAG : phase_r;
  assign cnt_cur   = first_of_file ? 2'd0 : cnt_r;
  assign end4      = cnt_cur == 2'd3;
  assign end2      = cnt_cur == 2'd1;

  assign ch_ok   = (chans_r == 16'd1) || (chans_r == 16'd2);
  assign bits_ok = (sh16_bits == 16'd8) || (sh16_bits == 16'd16) || (sh16_bits == 16'd32);
  assign rate_ok = (rate_r == rates.low) || (rate_r == rates.mid) || (rate_r == rates.high);

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    tag_nxt      = tag_r;
    size_nxt     = size_r;
    skip_nxt     = skip_r;
    fmt_seen_nxt = fmt_seen_r;
    chans_nxt    = chans_r;
    rate_nxt     = rate_r;
    brate_nxt    = brate_r;
    align_nxt    = align_r;
    bits_nxt     = bits_r;
    active       = 1'b0;
    err          = 1'b0;
    ok           = 1'b0;
    status       = wavhp_pkg::ST_OK;

    // Restart or advance the byte position
    if (take) begin
      if (first_of_file) begin
        active       = 1'b1;
        pos_nxt      = '0;
        cnt_nxt      = '0;
        fmt_seen_nxt = 1'b0;
      end else if (phase_r != PH_IDLE && phase_r < PH_DONE) begin
        active  = 1'b1;
        pos_nxt = pos_r + 32'd1;
      end
    end

    if (active) begin
      phase_nxt = phase_cur;
      cnt_nxt   = cnt_cur + 2'd1;
      unique case (phase_cur)
        PH_RIFF_TAG: begin
          tag_nxt = sh32_tag;
          if (end4) begin
            cnt_nxt = '0;
            if (sh32_tag != wavhp_pkg::TAG_RIFF) begin
              err    = 1'b1;
              status = wavhp_pkg::ST_BAD_RIFF;
            end else begin
              phase_nxt = PH_RIFF_SIZE;
            end
          end
        end
        PH_RIFF_SIZE: begin
          size_nxt = sh32_size;
          if (end4) begin
            cnt_nxt   = '0;
            phase_nxt = PH_WAVE_TAG;
          end
        end
        PH_WAVE_TAG: begin
          tag_nxt = sh32_tag;
          if (end4) begin
            cnt_nxt = '0;
            if (sh32_tag != wavhp_pkg::TAG_WAVE) begin
              err    = 1'b1;
              status = wavhp_pkg::ST_BAD_WAVE;
            end else begin
              phase_nxt = PH_CHUNK_ID;
            end
          end
        end
        PH_CHUNK_ID: begin
          tag_nxt = sh32_tag;
          if (end4) begin
            cnt_nxt   = '0;
            phase_nxt = PH_CHUNK_SIZE;
          end
        end
        PH_CHUNK_SIZE: begin
          size_nxt = sh32_size;
          if (end4) begin
            cnt_nxt  = '0;
            skip_nxt = sh32_size;
            priority if (tag_r == wavhp_pkg::TAG_FMT && !fmt_seen_r) begin
              phase_nxt = PH_FMT_FORMAT;
            end else if (tag_r == wavhp_pkg::TAG_DATA && fmt_seen_r) begin
              ok = 1'b1;
            end else if (sh32_size == 32'd0) begin
              phase_nxt = PH_CHUNK_ID;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_FMT_FORMAT: begin
          bits_nxt = sh16_bits;
          if (end2) begin
            cnt_nxt = '0;
            if (sh16_bits != wavhp_pkg::PCM_FORMAT) begin
              err    = 1'b1;
              status = wavhp_pkg::ST_NOT_PCM;
            end else begin
              phase_nxt = PH_FMT_CHANNELS;
            end
          end
        end
        PH_FMT_CHANNELS: begin
          chans_nxt = sh16_chans;
          if (end2) begin
            cnt_nxt   = '0;
            phase_nxt = PH_FMT_RATE;
          end
        end
        PH_FMT_RATE: begin
          rate_nxt = sh32_rate;
          if (end4) begin
            cnt_nxt   = '0;
            phase_nxt = PH_FMT_BYTERATE;
          end
        end
        PH_FMT_BYTERATE: begin
          brate_nxt = sh32_brate;
          if (end4) begin
            cnt_nxt   = '0;
            phase_nxt = PH_FMT_ALIGN;
          end
        end
        PH_FMT_ALIGN: begin
          align_nxt = sh16_align;
          if (end2) begin
            cnt_nxt   = '0;
            phase_nxt = PH_FMT_BITS;
          end
        end
        PH_FMT_BITS: begin
          bits_nxt = sh16_bits;
          if (end2) begin
            cnt_nxt  = '0;
            skip_nxt = fmt_rest;
            // Unsupported fields win over a short chunk
            priority if (!ch_ok || !bits_ok || !rate_ok) begin
              err    = 1'b1;
              status = wavhp_pkg::ST_UNSUPPORT;
            end else if (size_r < 32'd16) begin
              err    = 1'b1;
              status = wavhp_pkg::ST_SHORT_FMT;
            end else begin
              fmt_seen_nxt = 1'b1;
              if (fmt_rest != 32'd0) begin
                phase_nxt = PH_SKIP;
              end else begin
                phase_nxt = size_r[0] ? PH_PAD : PH_CHUNK_ID;
              end
            end
          end
        end
        PH_SKIP: begin
          cnt_nxt  = cnt_r;
          skip_nxt = skip_dec;
          if (skip_dec == 32'd0) begin
            phase_nxt = size_r[0] ? PH_PAD : PH_CHUNK_ID;
          end
        end
        PH_PAD: begin
          cnt_nxt   = cnt_r;
          phase_nxt = PH_CHUNK_ID;
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase

      // Early end: status by where the parse stands
      if (!err && !ok && last_of_file) begin
        err = 1'b1;
        priority if (phase_nxt == PH_RIFF_TAG) begin
          status = wavhp_pkg::ST_BAD_RIFF;
        end else if (phase_nxt == PH_RIFF_SIZE || phase_nxt == PH_WAVE_TAG) begin
          status = wavhp_pkg::ST_BAD_WAVE;
        end else if (phase_nxt >= PH_FMT_FORMAT && phase_nxt <= PH_FMT_BITS) begin
          status = wavhp_pkg::ST_SHORT_FMT;
        end else begin
          status = fmt_seen_nxt ? wavhp_pkg::ST_NO_DATA : wavhp_pkg::ST_NO_FMT;
        end
      end

      if (err || ok) begin
        phase_nxt = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r   <= tag_nxt;
    size_r  <= size_nxt;
    skip_r  <= skip_nxt;
    chans_r <= chans_nxt;
    rate_r  <= rate_nxt;
    brate_r <= brate_nxt;
    align_r <= align_nxt;
    bits_r  <= bits_nxt;
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cnt_r      <= '0;
      pos_r      <= '0;
      fmt_seen_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      pos_r      <= pos_nxt;
      fmt_seen_r <= fmt_seen_nxt;
    end
  end

  // Result fields; all zero beside the status on an error
  always_comb begin
    hdr        = '0;
    hdr.status = status;
    if (ok) begin
      hdr.channel_count    = chans_r[1:0];
      hdr.sample_rate      = rate_r;
      hdr.sample_bits      = bits_r[5:0];
      hdr.bytes_per_second = brate_r;
      hdr.block_bytes      = align_r;
      hdr.data_length      = sh32_size;
      hdr.data_start       = pos_nxt + 32'd1;
    end
  end

  assign emit          = err || ok;
  assign div_req.start = ok;
  assign div_req.num   = sh32_size;
  assign div_req.den   = align_r;

endmodule

[src/wav_header_parser.sv]
// Top level of the RIFF/WAVE header parser: registers, parser, divider, result.
//
//  channel | direction | handshake         | carries
//  in_     | in        | in_valid/in_stall | file_byte, first_of_file, last_of_file
//  out_    | out       | out_valid/out_stall | status and header fields, block_total
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (allowed rates)
//
// One file byte is taken per cycle while the header is walked and in_stall is low.
// A data chunk starts the divider, with in_stall high from the last size byte
// until the result.
// in_stall stays high while a result waits on out_stall; error results come
// in the cycle after the byte that causes them.
// Synchronous reset sets the rate registers to 11025, 22050 and 44100 Hz.
module wav_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_file_byte,
  input  logic        in_first_of_file,
  input  logic        in_last_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [1:0]  out_channel_count,
  output logic [31:0] out_sample_rate,
  output logic [5:0]  out_sample_bits,
  output logic [31:0] out_bytes_per_second,
  output logic [15:0] out_block_bytes,
  output logic [31:0] out_data_length,
  output logic [31:0] out_data_start,
  output logic [31:0] out_block_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  wavhp_pkg::wavhp_rates_t   rates_r, rates_nxt;
  wavhp_pkg::wavhp_hdr_t     hdr;
  wavhp_pkg::wavhp_hdr_t     hdr_r, hdr_nxt;
  wavhp_pkg::wavhp_div_req_t div_req;
  logic [31:0] total_r, total_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        wait_div_r, wait_div_nxt;
  logic        take;
  logic        emit;
  logic        div_busy;
  logic        div_done;
  logic [31:0] div_quo;

  assign cfg_ready = 1'b1;
  assign in_stall  = wait_div_r || out_valid_r;
  assign take      = in_valid && !in_stall;

  // Rate registers
  always_comb begin
    rates_nxt = rates_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        wavhp_pkg::REG_RATE_LOW:  rates_nxt.low  = cfg_data;
        wavhp_pkg::REG_RATE_MID:  rates_nxt.mid  = cfg_data;
        wavhp_pkg::REG_RATE_HIGH: rates_nxt.high = cfg_data;
        default: rates_nxt = rates_r;
      endcase
    end
  end

  wavhp_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .file_byte     (in_file_byte),
    .first_of_file (in_first_of_file),
    .last_of_file  (in_last_of_file),
    .rates         (rates_r),
    .emit          (emit),
    .hdr           (hdr),
    .div_req       (div_req)
  );

  wavhp_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Result register: errors go out at once, a good header after the divide
  always_comb begin
    hdr_nxt       = hdr_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    wait_div_nxt  = wait_div_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      hdr_nxt   = hdr;
      total_nxt = '0;
      if (div_req.start) begin
        wait_div_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b1;
      end
    end
    if (wait_div_r && div_done && !div_busy) begin
      total_nxt     = div_quo;
      wait_div_nxt  = 1'b0;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r   <= hdr_nxt;
    total_r <= total_nxt;
    if (!rst_n) begin
      rates_r.low  <= wavhp_pkg::RATE_LOW_RST;
      rates_r.mid  <= wavhp_pkg::RATE_MID_RST;
      rates_r.high <= wavhp_pkg::RATE_HIGH_RST;
      out_valid_r  <= 1'b0;
      wait_div_r   <= 1'b0;
    end else begin
      rates_r     <= rates_nxt;
      out_valid_r <= out_valid_nxt;
      wait_div_r  <= wait_div_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = hdr_r.status;
  assign out_channel_count    = hdr_r.channel_count;
  assign out_sample_rate      = hdr_r.sample_rate;
  assign out_sample_bits      = hdr_r.sample_bits;
  assign out_bytes_per_second = hdr_r.bytes_per_second;
  assign out_block_bytes      = hdr_r.block_bytes;
  assign out_data_length      = hdr_r.data_length;
  assign out_data_start       = hdr_r.data_start;
  assign out_block_total      = total_r;

endmodule

[src/wavhp_checker.sv]
// Port-level checks on the WAV header parser results, bound to the top level.
`include "wav_header_parser_defines.svh"

module wavhp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [1:0]  out_channel_count,
  input logic [31:0] out_sample_rate,
  input logic [5:0]  out_sample_bits,
  input logic [15:0] out_block_bytes,
  input logic [31:0] out_data_length,
  input logic [31:0] out_block_total
);

  // A held result stays put
  `WAVHP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_status) && $stable(out_block_total),
    "result changed while stalled")

  // Error results carry nothing but the status
  `WAVHP_ASSERT_IMP(a_err_zero, out_valid && out_status != wavhp_pkg::ST_OK,
    out_sample_rate == 32'd0 && out_data_length == 32'd0 && out_block_total == 32'd0,
    "error result with non-zero fields")

  // A good header has a supported shape
  `WAVHP_ASSERT_IMP(a_ok_shape, out_valid && out_status == wavhp_pkg::ST_OK,
    (out_channel_count == 2'd1 || out_channel_count == 2'd2) &&
    (out_sample_bits == 6'd8 || out_sample_bits == 6'd16 || out_sample_bits == 6'd32),
    "good header with unsupported shape")

  // Zero align gives a zero block count
  `WAVHP_ASSERT_IMP(a_zero_align, out_valid && out_block_bytes == 16'd0,
    out_block_total == 32'd0, "block count non-zero for zero align")

  // No byte is taken while a result waits
  `WAVHP_ASSERT_IMP(a_stall_out, out_valid, in_stall,
    "input open while a result waits")

endmodule

bind wav_header_parser wavhp_checker u_wavhp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_channel_count (out_channel_count),
  .out_sample_rate   (out_sample_rate),
  .out_sample_bits   (out_sample_bits),
  .out_block_bytes   (out_block_bytes),
  .out_data_length   (out_data_length),
  .out_block_total   (out_block_total)
);

[verif/tb_wav_header_parser.sv]
// Self-checking testbench for the RIFF/WAVE header parser, with a byte-level predictor.
`timescale 1ns / 100ps

module tb_wav_header_parser;

  localparam int SETTLE_CYCLES = 40;      // divider pass plus margin
  localparam int TIMEOUT_NS    = 1_000_000;
  localparam int MAX_REPORTS   = 100;

  // Parse position of the predictor
  typedef enum logic [4:0] {
    WAIT_START, IN_RIFF_TAG, IN_RIFF_SIZE, IN_WAVE_TAG, IN_CHUNK_TAG, IN_CHUNK_SIZE,
    IN_FORMAT, IN_CHANNELS, IN_RATE, IN_BYTE_RATE, IN_ALIGN, IN_BITS, IN_SKIP, IN_PAD,
    FILE_DONE
  } parse_pos_t;

  typedef struct packed {
    wavhp_pkg::wavhp_hdr_t hdr;
    logic [31:0]           block_total;
  } header_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_file_byte;
  logic        in_first_of_file;
  logic        in_last_of_file;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [1:0]  out_channel_count;
  logic [31:0] out_sample_rate;
  logic [5:0]  out_sample_bits;
  logic [31:0] out_bytes_per_second;
  logic [15:0] out_block_bytes;
  logic [31:0] out_data_length;
  logic [31:0] out_data_start;
  logic [31:0] out_block_total;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  wav_header_parser i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_file_byte         (in_file_byte),
    .in_first_of_file     (in_first_of_file),
    .in_last_of_file      (in_last_of_file),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_channel_count    (out_channel_count),
    .out_sample_rate      (out_sample_rate),
    .out_sample_bits      (out_sample_bits),
    .out_bytes_per_second (out_bytes_per_second),
    .out_block_bytes      (out_block_bytes),
    .out_data_length      (out_data_length),
    .out_data_start       (out_data_start),
    .out_block_total      (out_block_total),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Pacing and bookkeeping
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned file_bytes_sent;
  int unsigned files_sent;
  int unsigned ok_headers;
  int unsigned error_headers;

  header_result_t expected_headers[$];
  logic [7:0]     file_bytes[$];

  // Predictor state
  wavhp_pkg::wavhp_rates_t allowed_rates;
  parse_pos_t   rx_pos;
  int unsigned  fld_idx;
  logic [31:0]  fld_acc;
  logic [31:0]  byte_pos;
  logic [31:0]  chunk_tag;
  logic [31:0]  chunk_size;
  logic [31:0]  skip_left;
  logic         fmt_seen;
  logic [15:0]  fmt_channels;
  logic [31:0]  fmt_rate;
  logic [31:0]  fmt_byte_rate;
  logic [15:0]  fmt_align;
  logic [15:0]  fmt_bits;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_parse();
    rx_pos        = WAIT_START;
    fld_idx       = 0;
    fld_acc       = '0;
    byte_pos      = '0;
    chunk_tag     = '0;
    chunk_size    = '0;
    skip_left     = '0;
    fmt_seen      = 1'b0;
    fmt_channels  = '0;
    fmt_rate      = '0;
    fmt_byte_rate = '0;
    fmt_align     = '0;
    fmt_bits      = '0;
  endfunction

  // Little-endian field assembly; true on the last byte of the field
  function automatic bit take_field(input logic [7:0] b, input int unsigned len);
    if (fld_idx == 0) fld_acc = '0;
    fld_acc = fld_acc | (32'(b) << (8 * fld_idx));
    fld_idx++;
    if (fld_idx >= len) begin
      fld_idx = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void finish_chunk();
    rx_pos = chunk_size[0] ? IN_PAD : IN_CHUNK_TAG;
  endfunction

  function automatic void start_skip(input logic [31:0] n);
    skip_left = n;
    if (n == 0) finish_chunk();
    else rx_pos = IN_SKIP;
  endfunction

  function automatic void push_error(input logic [2:0] st);
    header_result_t r;
    r            = '0;
    r.hdr.status = st;
    expected_headers.push_back(r);
    rx_pos = FILE_DONE;
  endfunction

  function automatic void push_header();
    header_result_t r;
    r                      = '0;
    r.hdr.status           = wavhp_pkg::ST_OK;
    r.hdr.channel_count    = fmt_channels[1:0];
    r.hdr.sample_rate      = fmt_rate;
    r.hdr.sample_bits      = fmt_bits[5:0];
    r.hdr.bytes_per_second = fmt_byte_rate;
    r.hdr.block_bytes      = fmt_align;
    r.hdr.data_length      = chunk_size;
    r.hdr.data_start       = byte_pos + 32'd1;
    r.block_total          = (fmt_align == 0) ? 32'd0 : chunk_size / 32'(fmt_align);
    expected_headers.push_back(r);
    rx_pos = FILE_DONE;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input bit first, input bit last);
    bit ch_ok, bits_ok, rate_ok;
    if (first) begin
      clear_parse();
      rx_pos = IN_RIFF_TAG;
    end else if (rx_pos == WAIT_START || rx_pos == FILE_DONE) begin
      return;
    end else begin
      byte_pos++;
    end

    case (rx_pos)
      IN_RIFF_TAG: if (take_field(b, 4)) begin
        chunk_tag = fld_acc;
        if (chunk_tag != wavhp_pkg::TAG_RIFF) push_error(wavhp_pkg::ST_BAD_RIFF);
        else rx_pos = IN_RIFF_SIZE;
      end
      IN_RIFF_SIZE: if (take_field(b, 4)) begin
        chunk_size = fld_acc;
        rx_pos     = IN_WAVE_TAG;
      end
      IN_WAVE_TAG: if (take_field(b, 4)) begin
        chunk_tag = fld_acc;
        if (chunk_tag != wavhp_pkg::TAG_WAVE) push_error(wavhp_pkg::ST_BAD_WAVE);
        else rx_pos = IN_CHUNK_TAG;
      end
      IN_CHUNK_TAG: if (take_field(b, 4)) begin
        chunk_tag = fld_acc;
        rx_pos    = IN_CHUNK_SIZE;
      end
      IN_CHUNK_SIZE: if (take_field(b, 4)) begin
        chunk_size = fld_acc;
        // only the first fmt is parsed; data counts once a good fmt is held
        if (chunk_tag == wavhp_pkg::TAG_FMT && !fmt_seen) rx_pos = IN_FORMAT;
        else if (chunk_tag == wavhp_pkg::TAG_DATA && fmt_seen) push_header();
        else start_skip(chunk_size);
      end
      IN_FORMAT: if (take_field(b, 2)) begin
        fmt_bits = fld_acc[15:0];
        if (fmt_bits != wavhp_pkg::PCM_FORMAT) push_error(wavhp_pkg::ST_NOT_PCM);
        else rx_pos = IN_CHANNELS;
      end
      IN_CHANNELS: if (take_field(b, 2)) begin
        fmt_channels = fld_acc[15:0];
        rx_pos       = IN_RATE;
      end
      IN_RATE: if (take_field(b, 4)) begin
        fmt_rate = fld_acc;
        rx_pos   = IN_BYTE_RATE;
      end
      IN_BYTE_RATE: if (take_field(b, 4)) begin
        fmt_byte_rate = fld_acc;
        rx_pos        = IN_ALIGN;
      end
      IN_ALIGN: if (take_field(b, 2)) begin
        fmt_align = fld_acc[15:0];
        rx_pos    = IN_BITS;
      end
      IN_BITS: if (take_field(b, 2)) begin
        fmt_bits = fld_acc[15:0];
        ch_ok    = fmt_channels == 16'd1 || fmt_channels == 16'd2;
        bits_ok  = fmt_bits == 16'd8 || fmt_bits == 16'd16 || fmt_bits == 16'd32;
        rate_ok  = fmt_rate == allowed_rates.low || fmt_rate == allowed_rates.mid ||
                   fmt_rate == allowed_rates.high;
        // unsupported wins over a short chunk
        if (!ch_ok || !bits_ok || !rate_ok) push_error(wavhp_pkg::ST_UNSUPPORT);
        else if (chunk_size < 32'd16) push_error(wavhp_pkg::ST_SHORT_FMT);
        else begin
          fmt_seen = 1'b1;
          start_skip(chunk_size - 32'd16);
        end
      end
      IN_SKIP: begin
        skip_left--;
        if (skip_left == 0) finish_chunk();
      end
      IN_PAD: rx_pos = IN_CHUNK_TAG;
      default: ;
    endcase

    // early end of file: status follows the parse position
    if (last && rx_pos != FILE_DONE) begin
      if (rx_pos == IN_RIFF_TAG) push_error(wavhp_pkg::ST_BAD_RIFF);
      else if (rx_pos == IN_RIFF_SIZE || rx_pos == IN_WAVE_TAG)
        push_error(wavhp_pkg::ST_BAD_WAVE);
      else if (rx_pos >= IN_FORMAT && rx_pos <= IN_BITS) push_error(wavhp_pkg::ST_SHORT_FMT);
      else push_error(fmt_seen ? wavhp_pkg::ST_NO_DATA : wavhp_pkg::ST_NO_FMT);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    header_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_headers.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, status %0d", out_status));
      end else begin
        want = expected_headers.pop_front();
        check_field("status", out_status, want.hdr.status);
        check_field("channel_count", out_channel_count, want.hdr.channel_count);
        check_field("sample_rate", out_sample_rate, want.hdr.sample_rate);
        check_field("sample_bits", out_sample_bits, want.hdr.sample_bits);
        check_field("bytes_per_second", out_bytes_per_second, want.hdr.bytes_per_second);
        check_field("block_bytes", out_block_bytes, want.hdr.block_bytes);
        check_field("data_length", out_data_length, want.hdr.data_length);
        check_field("data_start", out_data_start, want.hdr.data_start);
        check_field("block_total", out_block_total, want.block_total);
        if (want.hdr.status == wavhp_pkg::ST_OK) ok_headers++;
        else error_headers++;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // One item on the input channel, with random idle cycles in front
  task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_file_byte     <= b;
    in_first_of_file <= first;
    in_last_of_file  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, first, last);
  endtask

  // Sends file_bytes up to last_at, flagging that byte as last; -1 sends all, unflagged
  task automatic send_file(input int last_at);
    int stop;
    stop = (last_at < 0) ? int'(file_bytes.size()) - 1 : last_at;
    for (int i = 0; i <= stop; i++) begin
      send_byte(file_bytes[i], i == 0, i == last_at);
      file_bytes_sent++;
    end
    files_sent++;
  endtask

  // Hold the input low until every result is in and the block has settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_headers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      wavhp_pkg::REG_RATE_LOW:  allowed_rates.low  = value;
      wavhp_pkg::REG_RATE_MID:  allowed_rates.mid  = value;
      wavhp_pkg::REG_RATE_HIGH: allowed_rates.high = value;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // File generation
  // ---------------------------------------------------------------------------

  function automatic void push16(input logic [15:0] v);
    file_bytes.push_back(v[7:0]);
    file_bytes.push_back(v[15:8]);
  endfunction

  function automatic void push32(input logic [31:0] v);
    for (int k = 0; k < 4; k++) file_bytes.push_back(v[8*k +: 8]);
  endfunction

  function automatic void add_chunk(input logic [31:0] tag, input logic [31:0] size);
    push32(tag);
    push32(size);
    for (int k = 0; k < size; k++) file_bytes.push_back(8'($urandom));
    if (size[0]) file_bytes.push_back(8'($urandom));
  endfunction

  // Mostly well-formed header with random content, sometimes broken
  task automatic build_file();
    int unsigned pick;
    int unsigned fmt_size;
    logic [31:0] rate;
    file_bytes.delete();
    push32(wavhp_pkg::TAG_RIFF);
    push32($urandom);
    push32(wavhp_pkg::TAG_WAVE);

    // unknown chunks and a data chunk ahead of fmt are skipped
    if ($urandom_range(3) == 0)
      for (int k = $urandom_range(1, 2); k > 0; k--) add_chunk($urandom, $urandom_range(9));
    if ($urandom_range(9) == 0) add_chunk(wavhp_pkg::TAG_DATA, $urandom_range(6));

    if ($urandom_range(19) != 0) begin
      pick     = $urandom_range(9);
      fmt_size = (pick < 7) ? 16 : (pick == 7) ? 18 :
                 (pick == 8) ? $urandom_range(17, 23) : $urandom_range(15);
      push32(wavhp_pkg::TAG_FMT);
      push32(fmt_size);
      push16(($urandom_range(9) != 0) ? wavhp_pkg::PCM_FORMAT : 16'($urandom));
      pick = $urandom_range(9);
      push16(pick < 8 ? 16'($urandom_range(1, 2)) : pick == 8 ? 16'($urandom_range(3)) :
             16'($urandom));
      pick = $urandom_range(7);
      rate = (pick == 0) ? $urandom : (pick < 3) ? allowed_rates.low :
             (pick < 5) ? allowed_rates.mid : allowed_rates.high;
      push32(rate);
      push32($urandom);
      pick = $urandom_range(9);
      push16(pick == 0 ? 16'd0 : pick == 1 ? 16'hFFFF :
             pick < 7 ? 16'($urandom_range(1, 8)) : 16'($urandom));
      pick = $urandom_range(11);
      push16(pick < 4 ? 16'd8 : pick < 7 ? 16'd16 : pick < 10 ? 16'd32 : 16'($urandom));
      for (int k = 16; k < fmt_size; k++) file_bytes.push_back(8'($urandom));
      if (fmt_size[0]) file_bytes.push_back(8'($urandom));
      // a second fmt is skipped
      if ($urandom_range(7) == 0) add_chunk(wavhp_pkg::TAG_FMT, 16);
    end

    if ($urandom_range(9) == 0) begin
      // oversized unknown chunk: the file ends inside its body
      push32($urandom);
      push32($urandom | 32'h100);
      for (int k = 0; k < 3; k++) file_bytes.push_back(8'($urandom));
    end else begin
      if ($urandom_range(4) == 0) add_chunk($urandom, $urandom_range(5));
      if ($urandom_range(9) != 0) begin
        push32(wavhp_pkg::TAG_DATA);
        pick = $urandom_range(5);
        push32(pick == 0 ? 32'd0 : pick == 1 ? 32'hFFFF_FFFF :
               pick == 2 ? 32'($urandom_range(200)) : $urandom);
        for (int k = $urandom_range(4); k > 0; k--) file_bytes.push_back(8'($urandom));
      end
    end

    if ($urandom_range(15) == 0)
      file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Stray bytes, tag errors, early ends, bytes after a result and a restart
  task automatic test_header_errors();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // ignored before any start
    send_byte(8'hAA, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b1);
    // "RIFX"
    file_bytes = '{8'h52, 8'h49, 8'h46, 8'h58};
    send_file(-1);
    // ignored after a result
    send_byte(8'h00, 1'b0, 1'b1);
    // file of one byte
    file_bytes = '{8'h52};
    send_file(0);
    // good RIFF, size all ones, "WAVF"
    file_bytes.delete();
    push32(wavhp_pkg::TAG_RIFF);
    push32(32'hFFFF_FFFF);
    push32(wavhp_pkg::TAG_WAVE ^ 32'h0300_0000);
    send_file(-1);
    // restart part-way through, then end inside the RIFF size
    file_bytes = '{8'h52, 8'h49};
    send_file(-1);
    file_bytes = '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'hFF};
    send_file(5);
  endtask

  task automatic configure_rates(input logic [31:0] lo, input logic [31:0] mid,
                                 input logic [31:0] hi);
    wait_drained();
    write_rate_reg(wavhp_pkg::REG_RATE_LOW, lo);
    write_rate_reg(wavhp_pkg::REG_RATE_MID, mid);
    write_rate_reg(wavhp_pkg::REG_RATE_HIGH, hi);
    cfg_valid <= 1'b0;
  endtask

  // Stream of random files at the given pacing, with noise and drain pauses
  task automatic test_file_stream(input int unsigned idle_pct, input int unsigned stall_pct,
                                  input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int          last_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = file_bytes_sent;
    while (file_bytes_sent - start < budget) begin
      build_file();
      pick = $urandom_range(99);
      if (pick < 85) last_at = file_bytes.size() - 1;
      else if (pick < 95) last_at = $urandom_range(file_bytes.size() - 1);
      else last_at = -1;
      send_file(last_at);
      // loose bytes, occasionally a restart
      if ($urandom_range(9) == 0)
        for (int k = $urandom_range(1, 4); k > 0; k--)
          send_byte(8'($urandom), $urandom_range(15) == 0, $urandom_range(3) == 0);
      if ($urandom_range(7) == 0) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_valid         <= 1'b0;
    in_file_byte     <= '0;
    in_first_of_file <= 1'b0;
    in_last_of_file  <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= wavhp_pkg::REG_RATE_LOW;
    cfg_data         <= '0;
    out_stall        <= 1'b0;
    rst_n            <= 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    mismatch_count   = 0;
    file_bytes_sent  = 0;
    files_sent       = 0;
    ok_headers       = 0;
    error_headers    = 0;
    allowed_rates    = '{low: wavhp_pkg::RATE_LOW_RST, mid: wavhp_pkg::RATE_MID_RST,
                         high: wavhp_pkg::RATE_HIGH_RST};
    clear_parse();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_header_errors();
    test_file_stream(0, 0, 470);
    configure_rates(32'd0, 32'hFFFF_FFFF, $urandom);
    test_file_stream(62, 0, 470);
    configure_rates(32'd8000, 32'd48000, 32'd96000);
    test_file_stream(0, 62, 470);
    configure_rates($urandom, $urandom_range(8000, 192000), wavhp_pkg::RATE_HIGH_RST);
    test_file_stream(32, 32, 470);
    wait_drained();

    $display("Covered %0d files (%0d file bytes) over four pacing mixes and four rate sets.",
             files_sent, file_bytes_sent);
    $display("Headers checked: %0d good, %0d with an error status, %0d mismatches.",
             ok_headers, error_headers, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results outstanding.", expected_headers.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
